// File: src/oes_pkg.sv
// Shared types and constants for the offset excursion sequencer.
// No dependencies.
package oes_pkg;

  localparam int unsigned PulseW   = 16;
  localparam int unsigned OffsetW  = 8;
  localparam int unsigned LimitW   = 7;
  localparam int unsigned DwellW   = 8;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [PulseW-1:0] OnThresholdRst  = 16'd1800;
  localparam logic [PulseW-1:0] OffThresholdRst = 16'd1000;
  localparam logic [LimitW-1:0] LimitRst        = 7'd21;
  localparam logic [DwellW-1:0] DwellRst        = 8'd21;

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_ON_THRESHOLD  = 2'd0,
    REG_OFF_THRESHOLD = 2'd1,
    REG_EXC_LIMIT     = 2'd2,
    REG_DWELL_TICKS   = 2'd3
  } cfg_reg_t;

  // pattern phases
  typedef enum logic [PhaseW-1:0] {
    PH_LAT_NEG  = 3'd0,
    PH_LAT_RET0 = 3'd1,
    PH_LAT_POS  = 3'd2,
    PH_LAT_RET1 = 3'd3,
    PH_LON_POS  = 3'd4,
    PH_LON_RET0 = 3'd5,
    PH_LON_NEG  = 3'd6,
    PH_LON_RET1 = 3'd7
  } phase_t;

endpackage

// File: src/offset_excursion_sequencer_unit.sv
// Offset excursion sequencer: enable logic and eight-phase offset pattern.
// The result is registered when the request is accepted.
// Throughput: one request per cycle; the state update is a single combinational pass.
// in_tready drops only while a result waits on a stalled output.
// Reset (rst_n low, synchronous) clears all sequencer state, drops the
// output request and restores the configuration registers to their defaults.
// Depends on oes_pkg.
module offset_excursion_sequencer_unit
  import oes_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // [15:0] pulse_width
  input  logic                in_tuser,   // [0] tick
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,  // [7:0] lat_offset, [15:8] lon_offset,
                                          // [18:16] phase, [23:19] zero
  output logic [1:0]          out_tuser,  // [0] enabled, [1] target_reached
  // configuration
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  // configuration registers
  logic [PulseW-1:0] on_thr_r;
  logic [PulseW-1:0] off_thr_r;
  logic [LimitW-1:0] limit_r;
  logic [DwellW-1:0] dwell_r;

  // sequencer state
  logic                      en_r,    en_nxt;
  phase_t                    phase_r, phase_nxt;
  logic [DwellW-1:0]         cnt_r,   cnt_nxt;
  logic                      done_r,  done_nxt;
  logic signed [OffsetW-1:0] lat_r,   lat_nxt;
  logic signed [OffsetW-1:0] lon_r,   lon_nxt;

  logic                      out_valid_r;
  logic [23:0]               out_data_r;
  logic [1:0]                out_user_r;

  logic                      accept;
  logic                      clr;
  logic                      step;
  logic signed [OffsetW-1:0] lat_a, lon_a, cur, tgt, lim_s, moved;
  logic                      hit;
  logic                      done_b;
  logic [DwellW-1:0]         cnt_b;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_thr_r  <= OnThresholdRst;
      off_thr_r <= OffThresholdRst;
      limit_r   <= LimitRst;
      dwell_r   <= DwellRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ON_THRESHOLD:  on_thr_r  <= cfg_wdata[PulseW-1:0];
        REG_OFF_THRESHOLD: off_thr_r <= cfg_wdata[PulseW-1:0];
        REG_EXC_LIMIT:     limit_r   <= cfg_wdata[LimitW-1:0];
        REG_DWELL_TICKS:   dwell_r   <= cfg_wdata[DwellW-1:0];
        default: ;
      endcase
    end
  end

  assign lim_s = $signed({1'b0, limit_r});

  always_comb begin
    // enable logic runs before the step
    en_nxt = en_r;
    clr    = 1'b0;
    if ((in_tdata > on_thr_r) && !en_r) begin
      en_nxt = 1'b1;
    end else if (in_tdata < off_thr_r) begin
      en_nxt = 1'b0;
      clr    = 1'b1;
    end

    lat_a     = clr ? '0 : lat_r;
    lon_a     = clr ? '0 : lon_r;
    phase_nxt = clr ? PH_LAT_NEG : phase_r;
    cnt_b     = clr ? '0 : cnt_r;
    step      = in_tuser && en_nxt;

    case (phase_nxt)
      PH_LAT_NEG, PH_LON_NEG: tgt = -lim_s;
      PH_LAT_POS, PH_LON_POS: tgt = lim_s;
      default:                tgt = '0;
    endcase

    cur   = phase_nxt[2] ? lon_a : lat_a;
    hit   = 1'b0;
    moved = cur;
    if (cur > tgt) begin
      moved = cur - 8'sd1;
    end else if (cur < tgt) begin
      moved = cur + 8'sd1;
    end else begin
      hit = 1'b1;
    end

    lat_nxt  = lat_a;
    lon_nxt  = lon_a;
    done_nxt = done_r;
    cnt_nxt  = cnt_b;
    if (step) begin
      if (phase_nxt[2]) lon_nxt = moved;
      else              lat_nxt = moved;
      done_b = done_r || hit;
      if (done_b && (cnt_b < dwell_r)) cnt_b = cnt_b + 8'd1;
      done_nxt = done_b;
      cnt_nxt  = cnt_b;
      if (cnt_b == dwell_r) begin
        done_nxt  = 1'b0;
        phase_nxt = phase_t'(phase_nxt + 3'd1);
        cnt_nxt   = '0;
      end
    end else begin
      done_b = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      phase_r     <= PH_LAT_NEG;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      lat_r       <= '0;
      lon_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        en_r    <= en_nxt;
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        done_r  <= done_nxt;
        lat_r   <= lat_nxt;
        lon_r   <= lon_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {5'd0, phase_nxt, lon_nxt, lat_nxt};
      out_user_r <= {done_nxt, en_nxt};
    end
  end

`ifndef SYNTH
  // a disabled sequencer always sits at the origin of the pattern
  a_disabled_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !en_r |-> (lat_r == '0) && (lon_r == '0) && (phase_r == PH_LAT_NEG))
    else $error("disabled sequencer holds motion state");

  // offsets stay within the symmetric range
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lat_r != 8'sh80) && (lon_r != 8'sh80))
    else $error("offset reached -128");

  // the phase only advances by one or restarts
  a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != $past(phase_r)) |->
      (phase_r == PH_LAT_NEG) || (phase_r == phase_t'($past(phase_r) + 3'd1)))
    else $error("phase jumped");
`endif

endmodule
